FILE: design/lifo_list_with_search_top_assert.svh
// Assertion macros for the LIFO list with search.
// Used by the checker module; depends on nothing else.
`ifndef LIFO_LIST_WITH_SEARCH_TOP_ASSERT_SVH
`define LIFO_LIST_WITH_SEARCH_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LLS_ASSERT_ON(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define LLS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: design/lls_pkg.sv
// Package for the LIFO list with search: command, status and state codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lls_pkg;

	// Commands carried by an input transaction.
	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_LIST   = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	// Status codes carried by a result transaction.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMIT
	} lls_state_t;

	localparam int unsigned DATA_W = 32;

endpackage

FILE: design/lls_mem.sv
// Entry store for the LIFO list: one write port and one registered read port.
// Depends on lls_pkg for the data width.
`timescale 1ns / 1ps

module lls_mem
	import lls_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/lls_ctrl.sv
// Sequencer for the LIFO list: entry count, read pointer, shared comparator
// and the result register. Depends on lls_pkg; drives the ports of lls_mem.
`timescale 1ns / 1ps

module lls_ctrl
	import lls_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4,
	parameter int unsigned CW    = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	input  logic [DATA_W-1:0] operand_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [DATA_W-1:0] entry_value,
	output logic              last_of_run,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [DATA_W-1:0] wr_data,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  logic [DATA_W-1:0] rd_data
);

	lls_state_t        state_q, state_d;
	cmd_t              cmd_q;
	cmd_t              cmd_in;
	logic [DATA_W-1:0] operand_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     ptr_q;
	status_t           status_q;
	logic [DATA_W-1:0] value_q;
	logic              last_q;

	logic              accept;
	logic              is_empty;
	logic              is_full;
	logic              hit;
	logic              ptr_zero;
	logic [CW-1:0]     count_dec;
	logic [AW-1:0]     ptr_dec;
	logic              list_more;

	assign cmd_in    = cmd_t'(command);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CW'(DEPTH));
	assign count_dec = count_q - CW'(1);
	assign ptr_dec   = ptr_q - AW'(1);
	assign ptr_zero  = (ptr_q == '0);
	// The shared comparator: one stored entry against the operand per cycle.
	assign hit       = (rd_data == operand_q);
	assign list_more = (cmd_q == CMD_LIST) && !last_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (cmd_in == CMD_PUSH || is_empty) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				if (cmd_q != CMD_SEARCH || hit || ptr_zero) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_ready) begin
					state_d = list_more ? S_READ : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and memory port outputs.
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_EMIT);
		wr_en     = accept && (cmd_in == CMD_PUSH) && !is_full;
		wr_addr   = count_q[AW-1:0];
		wr_data   = operand_value;
		rd_en     = 1'b0;
		rd_addr   = ptr_dec;
		case (state_q)
			S_IDLE: begin
				rd_en   = in_valid && (cmd_in != CMD_PUSH) && !is_empty;
				rd_addr = count_dec[AW-1:0];
			end
			S_READ: begin
				rd_en = (cmd_q == CMD_SEARCH) && !hit && !ptr_zero;
			end
			S_EMIT: begin
				rd_en = out_ready && list_more;
			end
			default: rd_en = 1'b0;
		endcase
	end

	// Control registers: state, entry count and read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ptr_q <= count_dec[AW-1:0];
						if (cmd_in == CMD_PUSH && !is_full) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				S_READ: begin
					if (cmd_q == CMD_POP) begin
						count_q <= count_dec;
					end else if (cmd_q == CMD_SEARCH && !hit && !ptr_zero) begin
						ptr_q <= ptr_dec;
					end
				end
				S_EMIT: begin
					if (out_ready && list_more) begin
						ptr_q <= ptr_dec;
					end
				end
				default: ptr_q <= ptr_q;
			endcase
		end
	end

	// Command latch and result register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q     <= cmd_in;
					operand_q <= operand_value;
					value_q   <= '0;
					last_q    <= 1'b1;
					if (cmd_in == CMD_PUSH) begin
						status_q <= is_full ? ST_FULL : ST_OK;
					end else begin
						status_q <= ST_EMPTY;
					end
				end
			end
			S_READ: begin
				case (cmd_q)
					CMD_SEARCH: begin
						if (hit) begin
							status_q <= ST_OK;
							value_q  <= operand_q;
						end else begin
							status_q <= ST_MISS;
							value_q  <= '0;
						end
						last_q <= 1'b1;
					end
					CMD_LIST: begin
						status_q <= ST_OK;
						value_q  <= rd_data;
						last_q   <= ptr_zero;
					end
					default: begin
						status_q <= ST_OK;
						value_q  <= rd_data;
						last_q   <= 1'b1;
					end
				endcase
			end
			default: value_q <= value_q;
		endcase
	end

	assign status      = status_q;
	assign entry_value = value_q;
	assign last_of_run = last_q;

endmodule

FILE: design/lifo_list_with_search_top.sv
// Top level of the LIFO list with search: sequencer plus entry store.
// Depends on lls_pkg, lls_ctrl and lls_mem.
`timescale 1ns / 1ps

// A bounded last-in first-out store of DEPTH signed 32-bit values with push,
// pop, list and search commands. One command is taken at a time: in_ready is
// high only while the block is idle, and it rises again in the cycle after the
// final result transaction of the previous command (last_of_run high) is
// taken. The entry store has one read port with a registered output, and a
// single 32-bit comparator checks one entry per cycle, so these set the rate.
// A push, and any command on an empty store, goes straight from acceptance
// to its result. A pop reads the top entry first. A search reads entries
// newest first and stops at a hit or after the oldest entry (a miss). A list
// gives one result per entry, newest first, with a store read before each.
// No clearing pass is made after reset; only entries below the count are read.
module lifo_list_with_search_top
	import lls_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] operand_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] entry_value,
	output logic               last_of_run
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic [DATA_W-1:0] entry_bits;

	// Sequencer with the shared comparator.
	lls_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.operand_value (DATA_W'(unsigned'(operand_value))),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.entry_value   (entry_bits),
		.last_of_run   (last_of_run),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	// Entry store.
	lls_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign entry_value = signed'(entry_bits);

endmodule

FILE: design/lls_checker.sv
// Port-level checker for the LIFO list with search, bound to the top level.
// Depends on lls_pkg and lifo_list_with_search_top_assert.svh.
`timescale 1ns / 1ps
`include "lifo_list_with_search_top_assert.svh"

module lls_port_checker
	import lls_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic signed [31:0] entry_value,
	input logic               last_of_run
);

	// No result is shown while reset is asserted.
	`LLS_ASSERT_ALWAYS(a_no_out_in_reset, clk, !arst_n |-> !out_valid, "result valid in reset")

	// A new command is never taken while a result is still pending.
	`LLS_ASSERT_ON(a_one_at_a_time, clk, arst_n, !(in_ready && out_valid), "ready with result pending")

	// Any status other than ok ends the run and carries a zero value.
	`LLS_ASSERT_ON(a_status_ends_run, clk, arst_n, (out_valid && status != ST_OK) |-> (last_of_run && entry_value == 32'sd0), "non-ok status not final")

	// After the final result of a command is taken, the block is idle again.
	`LLS_ASSERT_ON(a_idle_after_last, clk, arst_n, (out_valid && out_ready && last_of_run) |=> in_ready, "not ready after final result")

	// A stalled result holds its payload.
	`LLS_ASSERT_ON(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(entry_value) && $stable(last_of_run)), "stalled result changed")

endmodule

bind lifo_list_with_search_top lls_port_checker u_lls_checker (.*);

FILE: dv/lls_checker.sv
// Checker for the LIFO list with search: watches both channels, predicts results, compares them.
// Depends on lls_pkg for the command and status codes.
`timescale 1ns / 1ps

module lls_checker
	import lls_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] operand_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic signed [31:0] entry_value,
	input  logic               last_of_run,
	output int                 fail_count,
	output int                 pending
);

	// One predicted result transaction.
	typedef struct packed {
		status_t           st;
		logic [DATA_W-1:0] val;
		logic              last;
	} lls_result_t;

	// Shadow copy of the stack and the results still to come.
	logic [DATA_W-1:0] stack_words [DEPTH];
	int unsigned       stack_depth;
	lls_result_t       result_q [$];
	int                mismatches;
	int                results_seen;

	function automatic lls_result_t make_result(status_t st, logic [DATA_W-1:0] val,
			logic last);
		lls_result_t r;
		r.st = st;
		r.val = val;
		r.last = last;
		return r;
	endfunction

	// Apply one accepted command to the shadow stack and queue its results.
	task automatic predict_command(input cmd_t cmd, input logic [DATA_W-1:0] operand);
		bit hit;
		hit = 1'b0;
		case (cmd)
			CMD_PUSH: begin
				if (stack_depth >= DEPTH) begin
					result_q.push_back(make_result(ST_FULL, '0, 1'b1));
				end else begin
					stack_words[stack_depth] = operand;
					stack_depth++;
					result_q.push_back(make_result(ST_OK, '0, 1'b1));
				end
			end
			CMD_POP: begin
				if (stack_depth == 0) begin
					result_q.push_back(make_result(ST_EMPTY, '0, 1'b1));
				end else begin
					stack_depth--;
					result_q.push_back(make_result(ST_OK, stack_words[stack_depth], 1'b1));
				end
			end
			CMD_LIST: begin
				if (stack_depth == 0) begin
					result_q.push_back(make_result(ST_EMPTY, '0, 1'b1));
				end else begin
					// Newest entry first, the oldest one marks the end of the run.
					for (int i = stack_depth; i > 0; i--)
						result_q.push_back(make_result(ST_OK, stack_words[i-1], i == 1));
				end
			end
			default: begin
				if (stack_depth == 0) begin
					result_q.push_back(make_result(ST_EMPTY, '0, 1'b1));
				end else begin
					for (int i = stack_depth; i > 0; i--)
						if (stack_words[i-1] == operand)
							hit = 1'b1;
					if (hit)
						result_q.push_back(make_result(ST_OK, operand, 1'b1));
					else
						result_q.push_back(make_result(ST_MISS, '0, 1'b1));
				end
			end
		endcase
	endtask

	// Compare one accepted result transaction with the oldest prediction.
	task automatic check_result();
		lls_result_t want;
		results_seen++;
		if (result_q.size() == 0) begin
			if (mismatches < 10)
				$display("ERROR: result %0d arrived with nothing predicted: status %0d value %h last %b",
					results_seen, status, entry_value, last_of_run);
			mismatches++;
		end else begin
			want = result_q.pop_front();
			if (status !== want.st || entry_value !== want.val || last_of_run !== want.last) begin
				if (mismatches < 10)
					$display("ERROR: result %0d: expected status %0d value %h last %b, got status %0d value %h last %b",
						results_seen, want.st, want.val, want.last,
						status, entry_value, last_of_run);
				mismatches++;
			end
		end
	endtask

	// Results are taken before commands: a result at the same edge always belongs to an older command.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_depth = 0;
			result_q.delete();
			mismatches = 0;
			results_seen = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				predict_command(cmd_t'(command), operand_value);
			pending <= result_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: dv/tb.sv
// Testbench top for the LIFO list with search: clock, reset, command stimulus and verdict.
// Depends on lls_pkg, lifo_list_with_search_top and lls_checker.
`timescale 1ns / 1ps

module tb;
	import lls_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam int RANDOM_ITEMS = 470;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         command;
	logic signed [31:0] operand_value;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] entry_value;
	logic               last_of_run;
	int                 fail_count;
	int                 pending;

	// Coordination between the command source and the result sink.
	bit          sink_hold_req;
	bit          tx_burst;
	logic [31:0] recent_pushes [8];
	int          recent_wr;

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	lifo_list_with_search_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.operand_value(operand_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_value(entry_value),
		.last_of_run(last_of_run)
	);

	lls_checker #(
		.DEPTH(DEPTH)
	) u_lls_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.operand_value(operand_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_value(entry_value),
		.last_of_run(last_of_run),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Offer one command transaction, with an optional idle gap first, and wait for acceptance.
	task automatic send_command(input cmd_t cmd, input logic [31:0] operand);
		while (!tx_burst && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		operand_value <= operand;
		if (cmd == CMD_PUSH) begin
			recent_pushes[recent_wr] = operand;
			recent_wr = (recent_wr + 1) % 8;
		end
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Command source.
	initial begin : stimulus
		cmd_t        cmd;
		logic [31:0] val;
		logic [31:0] newest;
		int          roll;
		bit          fill_phase;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_PUSH;
		operand_value <= '0;
		tx_burst = 1'b0;
		sink_hold_req = 1'b0;
		recent_wr = 0;
		for (int k = 0; k < 8; k++)
			recent_pushes[k] = $urandom;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// List, pop and search on an empty store.
		send_command(CMD_LIST, $urandom);
		send_command(CMD_POP, $urandom);
		send_command(CMD_SEARCH, $urandom);

		// Fill the store with extreme values, then random ones.
		send_command(CMD_PUSH, 32'h8000_0000);
		send_command(CMD_PUSH, 32'h7FFF_FFFF);
		send_command(CMD_PUSH, 32'h0000_0000);
		send_command(CMD_PUSH, 32'hFFFF_FFFF);
		send_command(CMD_PUSH, 32'h5555_5555);
		send_command(CMD_PUSH, 32'hAAAA_AAAA);
		newest = '0;
		repeat (10) begin
			newest = $urandom;
			send_command(CMD_PUSH, newest);
		end

		// Push into a full store, list it, search oldest, newest and a likely miss.
		send_command(CMD_PUSH, $urandom);
		send_command(CMD_LIST, $urandom);
		send_command(CMD_SEARCH, 32'h8000_0000);
		send_command(CMD_SEARCH, newest);
		send_command(CMD_SEARCH, 32'h1234_5678);
		send_command(CMD_POP, $urandom);

		// Random commands in alternating fill and drain phases.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			fill_phase = ((n / 40) % 2) == 0;
			tx_burst = (n >= 200 && n < 280);
			if (n == 120)
				sink_hold_req = 1'b1;
			if (n == 330) begin
				// Pause until every outstanding result has drained.
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			roll = $urandom_range(99);
			if (roll < (fill_phase ? 55 : 15))
				cmd = CMD_PUSH;
			else if (roll < 70)
				cmd = CMD_POP;
			else if (roll < 80)
				cmd = CMD_LIST;
			else
				cmd = CMD_SEARCH;
			case ($urandom_range(9))
				0, 1: val = recent_pushes[$urandom_range(7)];
				2: val = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				default: val = $urandom;
			endcase
			if (cmd == CMD_SEARCH && $urandom_range(1))
				val = recent_pushes[$urandom_range(7)];
			send_command(cmd, val);
		end

		// Drain and give the verdict.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result sink: random stalls, one long hold on request, and a window with no stalls.
	initial begin : sink
		int stall_left;
		int cycle_n;
		stall_left = 0;
		cycle_n = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle_n++;
			if (stall_left == 0 && sink_hold_req) begin
				sink_hold_req = 1'b0;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (cycle_n >= 2500 && cycle_n < 3300) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 19);
			end
		end
	end

	// Watchdog.
	initial begin : watchdog
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: lifo_list_with_search_top.f
+incdir+design
design/lls_pkg.sv
design/lls_mem.sv
design/lls_ctrl.sv
design/lifo_list_with_search_top.sv
design/lls_checker.sv
dv/lls_checker.sv
dv/tb.sv
